FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the generator's RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked property, ignored while reset is held.
`define XRG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("xrg assertion failed");
// Checked property that also covers the reset cycles.
`define XRG_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("xrg assertion failed");
`else
`define XRG_ASSERT(lbl, clk, rst_n, prop)
`define XRG_ASSERT_NR(lbl, clk, prop)
`endif
`endif

FILE: rtl/core/xrg_pkg.sv
// Package with the widths, constants, codes and command types of the generator.
`default_nettype none
package xrg_pkg;

    localparam int OPCODE_W = 3;
    localparam int WORD_W   = 64;
    localparam int HALF_W   = 32;
    localparam int BOUND_W  = 31;
    localparam int SKIP_W   = 16;
    localparam int DIV_CNT_W = 5;

    localparam logic [WORD_W-1:0] MIX_XL = 64'h9e3779b97f4a7c15;
    localparam logic [WORD_W-1:0] MIX_XH = 64'h6a09e667f3bcc909;
    localparam logic [WORD_W-1:0] MIX_A  = 64'hbf58476d1ce4e5b9;
    localparam logic [WORD_W-1:0] MIX_B  = 64'h94d049bb133111eb;

    // Operation codes carried by a request.
    typedef enum logic [OPCODE_W-1:0] {
        OP_SEED    = 3'd0,
        OP_NEXT    = 3'd1,
        OP_BOUNDED = 3'd2,
        OP_FLOAT   = 3'd3,
        OP_SKIP    = 3'd4,
        OP_PAIR    = 3'd5
    } t_opcode;

    // Which 32-bit halves feed the shared multiplier.
    typedef enum logic [1:0] {
        PART_LO = 2'd0,
        PART_HL = 2'd1,
        PART_LH = 2'd2
    } t_mul_part;

    // Multiplier operand pair.
    typedef enum logic [1:0] {
        MSRC_A     = 2'd0,
        MSRC_B     = 2'd1,
        MSRC_BOUND = 2'd2
    } t_mul_src;

    // Accumulator operation.
    typedef enum logic [1:0] {
        ACC_NONE = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2
    } t_acc_op;

    // Source of the result register.
    typedef enum logic [2:0] {
        RES_NONE  = 3'd0,
        RES_STEP  = 3'd1,
        RES_FLOAT = 3'd2,
        RES_POW2  = 3'd3,
        RES_MOD   = 3'd4,
        RES_PAIR  = 3'd5
    } t_res_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load;
        logic      step;
        logic      pre_a;
        logic      pre_b;
        logic      word;
        logic      mul_en;
        t_mul_part part;
        t_mul_src  msrc;
        t_acc_op   acc_op;
        logic      fin;
        logic      save_hi;
        logic      cnt_dec;
        logic      div_start;
        t_res_sel  res_sel;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pow2;
        logic cnt_zero;
        logic div_done;
        logic accept;
    } t_dp_stat;

endpackage
`default_nettype wire

FILE: rtl/core/xrg_if.sv
// Request and response channel interfaces of the generator.
`default_nettype none
interface xrg_req_if
    import xrg_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [WORD_W-1:0]   seed_value;
    logic [BOUND_W-1:0]  bound;
    logic [SKIP_W-1:0]   skip_count;

    modport source (output valid, output opcode, output seed_value, output bound,
                    output skip_count, input ready);
    modport sink (input valid, input opcode, input seed_value, input bound,
                  input skip_count, output ready);
endinterface

interface xrg_rsp_if
    import xrg_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/xrg_div.sv
// Restoring divider that yields the remainder of a 31-bit division, one bit a cycle.
`default_nettype none
`include "assert_macros.svh"
module xrg_div
    import xrg_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [BOUND_W-1:0] i_dividend,
    input  wire logic [BOUND_W-1:0] i_divisor,
    output logic                    o_done,
    output logic [BOUND_W-1:0]      o_rem
);

    localparam logic [DIV_CNT_W-1:0] LAST_BIT = DIV_CNT_W'(BOUND_W - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [BOUND_W-1:0]   r_dvd;
    logic [BOUND_W-1:0]   r_dsr;
    logic [BOUND_W-1:0]   r_rem;
    logic [BOUND_W:0]     shifted;
    logic [BOUND_W:0]     trial;

    // One restoring step: bring in the next dividend bit and try a subtract.
    assign shifted = {r_rem, r_dvd[BOUND_W-1]};
    assign trial   = shifted - {1'b0, r_dsr};

    // Control: busy for one cycle per dividend bit, then a done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_BIT) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operands and partial remainder.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[BOUND_W-2:0], 1'b0};
            if (!trial[BOUND_W]) begin
                r_rem <= trial[BOUND_W-1:0];
            end else begin
                r_rem <= shifted[BOUND_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    `XRG_ASSERT(a_div_start_idle, i_clk, i_rst_n, i_start |-> !r_busy)
    `XRG_ASSERT(a_div_rem_below, i_clk, i_rst_n, r_done |-> (r_rem < r_dsr))

endmodule
`default_nettype wire

FILE: rtl/core/xrg_dp.sv
// Datapath: generator state, seed mixer with a shared 32x32 multiplier, result logic.
`default_nettype none
`include "assert_macros.svh"
module xrg_dp
    import xrg_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    input  wire logic [WORD_W-1:0]  i_seed_value,
    input  wire logic [BOUND_W-1:0] i_bound,
    input  wire logic [SKIP_W-1:0]  i_skip_count,
    output t_dp_stat                o_stat,
    output logic [WORD_W-1:0]       o_value
);

    logic [WORD_W-1:0]  r_s0;
    logic [WORD_W-1:0]  r_s1;
    logic [WORD_W-1:0]  r_l;
    logic [BOUND_W-1:0] r_bound;
    logic [SKIP_W-1:0]  r_cnt;
    logic [WORD_W-1:0]  r_rnd;
    logic [WORD_W-1:0]  r_z;
    logic [WORD_W-1:0]  r_prod;
    logic [WORD_W-1:0]  r_acc;
    logic [HALF_W-1:0]  r_hi;
    logic [WORD_W-1:0]  r_res;

    logic [WORD_W-1:0]  sum;
    logic [WORD_W-1:0]  step_out;
    logic [WORD_W-1:0]  h;
    logic [WORD_W-1:0]  s0_next;
    logic [WORD_W-1:0]  s1_next;
    logic [WORD_W-1:0]  mix_in;
    logic [WORD_W-1:0]  mix_out;
    logic [WORD_W-1:0]  op_a;
    logic [WORD_W-1:0]  op_b;
    logic [HALF_W-1:0]  mul_a;
    logic [HALF_W-1:0]  mul_b;
    logic [WORD_W-1:0]  mul_p;
    logic [BOUND_W-1:0] draw;
    logic               div_done;
    logic [BOUND_W-1:0] div_rem;
    logic [HALF_W-1:0]  keep;
    logic [WORD_W-1:0]  res_next;

    // One generator step: output word and the next pair of state words.
    assign sum      = r_s0 + r_s1;
    assign step_out = {sum[46:0], sum[63:47]} + r_s0;
    assign h        = r_s1 ^ r_s0;
    assign s0_next  = {r_s0[14:0], r_s0[63:15]} ^ h ^ {h[42:0], 21'b0};
    assign s1_next  = {h[35:0], h[63:36]};

    // Seed expansion input for the low or high word, and final mix stage.
    assign mix_in  = i_cmd.word ? (r_l + MIX_XL) : r_l;
    assign mix_out = r_acc ^ {31'b0, r_acc[63:31]};

    // The top 31 bits of the latest step feed the bounded int paths.
    assign draw = r_rnd[63:33];

    // Operand pair for the shared multiplier.
    always_comb begin
        case (i_cmd.msrc)
            MSRC_A: begin
                op_a = r_z;
                op_b = MIX_A;
            end
            MSRC_B: begin
                op_a = r_z;
                op_b = MIX_B;
            end
            MSRC_BOUND: begin
                op_a = {33'b0, draw};
                op_b = {33'b0, r_bound};
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Half selection; the cross products only count in their low half.
    always_comb begin
        case (i_cmd.part)
            PART_LO: begin
                mul_a = op_a[31:0];
                mul_b = op_b[31:0];
            end
            PART_HL: begin
                mul_a = op_a[63:32];
                mul_b = op_b[31:0];
            end
            PART_LH: begin
                mul_a = op_a[31:0];
                mul_b = op_b[63:32];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Result value for the selected operation.
    assign keep = r_rnd[63:32];
    always_comb begin
        case (i_cmd.res_sel)
            RES_STEP:  res_next = r_rnd;
            RES_FLOAT: res_next = {40'b0, r_rnd[63:40]};
            RES_POW2:  res_next = {31'b0, r_acc[63:31]};
            RES_MOD:   res_next = {33'b0, div_rem};
            RES_PAIR:  res_next = {r_hi, 32'b0} + {{32{keep[31]}}, keep};
            default:   res_next = r_res;
        endcase
    end

    // Generator state words, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0 <= '0;
            r_s1 <= '0;
        end else if (i_cmd.step) begin
            r_s0 <= s0_next;
            r_s1 <= s1_next;
        end else if (i_cmd.fin) begin
            if (i_cmd.word) begin
                r_s1 <= mix_out;
            end else begin
                r_s0 <= mix_out;
            end
        end
    end

    // Request operands, skip counter, step capture and multiply pipeline.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_l     <= i_seed_value ^ MIX_XH;
            r_bound <= i_bound;
            r_cnt   <= i_skip_count;
        end else if (i_cmd.cnt_dec) begin
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.save_hi) begin
            r_hi <= r_rnd[63:32];
        end
        if (i_cmd.step) begin
            r_rnd <= step_out;
        end
        if (i_cmd.pre_a) begin
            r_z <= mix_in ^ {30'b0, mix_in[63:30]};
        end else if (i_cmd.pre_b) begin
            r_z <= r_acc ^ {27'b0, r_acc[63:27]};
        end
        if (i_cmd.mul_en) begin
            if (i_cmd.part == PART_LO) begin
                r_prod <= mul_p;
            end else begin
                r_prod <= {mul_p[31:0], 32'b0};
            end
        end
        case (i_cmd.acc_op)
            ACC_LOAD: r_acc <= r_prod;
            ACC_ADD:  r_acc <= r_acc + r_prod;
            default:  r_acc <= r_acc;
        endcase
        r_res <= res_next;
    end

    xrg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (draw),
        .i_divisor  (r_bound),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // Status: power-of-two bound (zero included), skip end, draw acceptance.
    logic [HALF_W-1:0] span;
    assign span = ({1'b0, draw} - {1'b0, div_rem}) + {1'b0, r_bound} - 32'd1;

    assign o_stat.pow2     = ((r_bound & (r_bound - 1'b1)) == '0);
    assign o_stat.cnt_zero = (r_cnt == '0);
    assign o_stat.div_done = div_done;
    assign o_stat.accept   = !span[31];
    assign o_value         = r_res;

    `XRG_ASSERT_NR(a_rst_clears_state, i_clk, !i_rst_n |=> (r_s0 == '0 && r_s1 == '0))

endmodule
`default_nettype wire

FILE: rtl/core/xrg_ctrl.sv
// Controller state machine that sequences each operation through the datapath.
`default_nettype none
`include "assert_macros.svh"
module xrg_ctrl
    import xrg_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic [OPCODE_W-1:0] i_opcode,
    output logic                     o_in_ready,
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    input  wire t_dp_stat            i_stat,
    output t_dp_cmd                  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRE_A,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_MUL_ACC,
        S_PRE_B,
        S_FIN,
        S_STEP,
        S_EVAL,
        S_DIV,
        S_PAIR,
        S_SKIP,
        S_RESULT
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_opcode r_op;
    logic    r_word;
    logic    r_phase;
    logic    r_out_valid;
    logic    accept_in;
    logic    slot_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept_in   = i_in_valid && o_in_ready;
    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.word = r_word;
        if (r_op == OP_BOUNDED) begin
            o_cmd.msrc = MSRC_BOUND;
        end else if (r_phase) begin
            o_cmd.msrc = MSRC_B;
        end else begin
            o_cmd.msrc = MSRC_A;
        end
        case (r_state)
            S_IDLE: begin
                if (accept_in) begin
                    o_cmd.load = 1'b1;
                    case (t_opcode'(i_opcode))
                        OP_SEED:    n_state = S_PRE_A;
                        OP_NEXT:    n_state = S_STEP;
                        OP_BOUNDED: n_state = S_STEP;
                        OP_FLOAT:   n_state = S_STEP;
                        OP_PAIR:    n_state = S_STEP;
                        OP_SKIP:    n_state = S_SKIP;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_PRE_A: begin
                o_cmd.pre_a = 1'b1;
                n_state     = S_MUL0;
            end
            S_PRE_B: begin
                o_cmd.pre_b = 1'b1;
                n_state     = S_MUL0;
            end
            S_MUL0: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.part   = PART_LO;
                n_state      = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.part   = PART_HL;
                o_cmd.acc_op = ACC_LOAD;
                n_state      = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.part   = PART_LH;
                o_cmd.acc_op = ACC_ADD;
                n_state      = S_MUL_ACC;
            end
            S_MUL_ACC: begin
                o_cmd.acc_op = ACC_ADD;
                if (r_op == OP_BOUNDED) begin
                    n_state = S_RESULT;
                end else if (r_phase) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_PRE_B;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = r_word ? S_IDLE : S_PRE_A;
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                case (r_op)
                    OP_BOUNDED: n_state = S_EVAL;
                    OP_PAIR:    n_state = S_PAIR;
                    default:    n_state = S_RESULT;
                endcase
            end
            S_PAIR: begin
                o_cmd.save_hi = 1'b1;
                o_cmd.step    = 1'b1;
                n_state       = S_RESULT;
            end
            S_EVAL: begin
                if (i_stat.pow2) begin
                    n_state = S_MUL0;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = i_stat.accept ? S_RESULT : S_STEP;
                end
            end
            S_SKIP: begin
                if (i_stat.cnt_zero) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.step    = 1'b1;
                    o_cmd.cnt_dec = 1'b1;
                end
            end
            S_RESULT: begin
                if (slot_free) begin
                    case (r_op)
                        OP_NEXT:    o_cmd.res_sel = RES_STEP;
                        OP_FLOAT:   o_cmd.res_sel = RES_FLOAT;
                        OP_PAIR:    o_cmd.res_sel = RES_PAIR;
                        OP_BOUNDED: o_cmd.res_sel = i_stat.pow2 ? RES_POW2 : RES_MOD;
                        default:    o_cmd.res_sel = RES_NONE;
                    endcase
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, sequencing flags and the output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_SEED;
            r_word      <= 1'b0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept_in) begin
                r_op   <= t_opcode'(i_opcode);
                r_word <= 1'b0;
            end else if (r_state == S_FIN) begin
                r_word <= 1'b1;
            end
            if (r_state == S_PRE_A) begin
                r_phase <= 1'b0;
            end else if (r_state == S_PRE_B) begin
                r_phase <= 1'b1;
            end
            if (o_cmd.res_sel != RES_NONE) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `XRG_ASSERT(a_result_slot_free, i_clk, i_rst_n, (o_cmd.res_sel != RES_NONE) |-> slot_free)

endmodule
`default_nettype wire

FILE: rtl/core/xoroshiro_random_generator.sv
// Top level of the xoroshiro128++ generator: controller, datapath and channel wiring.
//
// Usage: requests arrive on i_req (valid/ready); a transfer takes the opcode and its
// operands. Results leave on o_rsp (valid/ready), one 64-bit value per result.
// Seed, skip and unused opcodes produce no result; the others produce exactly one.
// Only one request is in work at a time: i_req.ready is high while the block is idle.
// What each request runs through from its transfer to result valid, before ready returns:
//   next long, float: one generator step, then the result register.
//   long from two high halves: two generator steps, then the result register.
//   bounded int, power-of-two or zero bound: a step, then one multiply of three partial products.
//   bounded int, other bounds: per draw, a step and a run of the bit-serial
//   remainder unit (one bit per cycle); a rejected draw repeats it.
//   seed: set by the shared 32x32 multiplier (four multiplies of
//   three partial products each).
//   skip: as many generator steps as the count, one generator step per cycle.
// The result sits in an output register; a new request is taken while it waits.
// If the receiver stalls, the next result waits in its final state until the
// register is free, and nothing is lost.
// Reset (i_rst_n low, synchronous) clears both state words to zero and empties the
// output; an unseeded generator returns zeros.
`default_nettype none
module xoroshiro_random_generator
    import xrg_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    xrg_req_if.sink   i_req,
    xrg_rsp_if.source o_rsp
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;
    logic     out_valid;

    // Operation sequencer.
    xrg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_opcode    (i_req.opcode),
        .o_in_ready  (in_ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (out_valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Generator state and arithmetic.
    xrg_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_seed_value (i_req.seed_value),
        .i_bound      (i_req.bound),
        .i_skip_count (i_req.skip_count),
        .o_stat       (stat),
        .o_value      (o_rsp.value)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;

endmodule
`default_nettype wire
